@@ design/priority_bitmap_run_queue_scheduler_top_macros.svh @@
// assertion macros for the run queue scheduler checker
`ifndef PRIORITY_BITMAP_RUN_QUEUE_SCHEDULER_TOP_MACROS_SVH
`define PRIORITY_BITMAP_RUN_QUEUE_SCHEDULER_TOP_MACROS_SVH
`define PBRQ_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define PBRQ_ASSERT_SYNC(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

@@ design/pbrq_pkg.sv @@
// shared types and constants of the run queue scheduler
package pbrq_pkg;
   localparam logic [2:0] ACT_CREATE   = 3'd0;
   localparam logic [2:0] ACT_WAKE     = 3'd1;
   localparam logic [2:0] ACT_BLOCK    = 3'd2;
   localparam logic [2:0] ACT_DESTROY  = 3'd3;
   localparam logic [2:0] ACT_TICK     = 3'd4;
   localparam logic [2:0] ACT_SCHEDULE = 3'd5;
   localparam logic [0:0] CSR_SLICE = 1'd0;
   localparam logic [0:0] CSR_IDLE  = 1'd1;
   localparam int TID_W = 8;
   localparam int LVL_W = 3;
   localparam int SLICE_W = 16;

   typedef struct packed {
      logic       capture;
      logic       do_remove;
      logic       do_insert;
      logic       do_schedule;
      logic       do_slice_load;
      logic       do_slice_dec;
      logic       use_runner;
      logic       ignored;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic       queued;
      logic       tid_ok;
      logic       pri_ok;
      logic       runner_is_idle;
      logic       runner_ok;
      logic       runner_queued;
      logic       slice_expired;
   } stat_type;
endpackage

@@ design/pbrq_if.sv @@
// valid/ready channel interface
interface pbrq_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ design/priority_bitmap_run_queue_scheduler_top.sv @@
// top level of the priority bitmap run queue scheduler
//  channel  | role   | payload
//  req      | sink   | action, thread number, priority_req
//  rsp      | source | current_thread .. status
//  csr      | write  | index 0 slice_ticks, 1 idle id
// link arrays are read through a registered port, one write per array per cycle
// a result waits in the output register; the next request is taken once it is
// in, so a stalled rsp holds one request back
// reset is synchronous and clears flags, counters and the running thread
module priority_bitmap_run_queue_scheduler_top #(
   parameter int THREADS = 256,
   parameter int LEVELS  = 5
) (
   input  logic         clock,
   input  logic         reset,
   pbrq_if.sink         req,
   pbrq_if.source       rsp,
   input  logic         csr_write,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_data
);
   pbrq_pkg::cmd_type  cmd;
   pbrq_pkg::stat_type stat;
   logic [7:0]  cur, prv;
   logic        sw, ign;
   logic [LEVELS-1:0] bm;
   logic [8:0]  cnt;
   logic [31:0] swc;
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;

   pbrq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .act(req.data[2:0]), .out_free(!rsp_valid_ff || rsp.ready),
      .stat(stat), .cmd(cmd)
   );

   pbrq_datapath #(.THREADS(THREADS), .LEVELS(LEVELS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .tid(req.data[10:3]), .pri(req.data[13:11]),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .cur_thread(cur), .prev_thread(prv), .sw(sw), .bitmap(bm), .count(cnt),
      .switches(swc), .ignored(ign)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish)
         rsp_data_ff <= {cur, prv, sw, 5'(bm), cnt, swc, ign};
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;
endmodule

@@ design/pbrq_ctrl.sv @@
// controller state machine of the run queue scheduler
module pbrq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [2:0]           act,
   input  logic                 out_free,
   input  pbrq_pkg::stat_type   stat,
   output pbrq_pkg::cmd_type    cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_DEC  = 3'd2;
   localparam logic [2:0] ST_REM  = 3'd3;
   localparam logic [2:0] ST_INS  = 3'd4;
   localparam logic [2:0] ST_SCH  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] act_ff, act_in;
   logic       ign_ff, ign_in;

   assign in_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         act_ff   <= 3'd0;
         ign_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
         ign_ff   <= ign_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      ign_in   = ign_ff;
      cmd      = '0;
      cmd.ignored    = ign_ff;
      cmd.use_runner = (act_ff == pbrq_pkg::ACT_TICK);
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.capture = 1'b1;
               act_in   = act;
               ign_in   = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_FIN;
            priority case (act_ff)
               pbrq_pkg::ACT_CREATE, pbrq_pkg::ACT_WAKE: begin
                  if (!stat.tid_ok || !stat.pri_ok || stat.queued) ign_in = 1'b1;
                  else state_in = ST_INS;
               end
               pbrq_pkg::ACT_BLOCK, pbrq_pkg::ACT_DESTROY: begin
                  if (!stat.tid_ok || !stat.queued) ign_in = 1'b1;
                  else state_in = ST_REM;
               end
               pbrq_pkg::ACT_TICK: begin
                  if (stat.runner_is_idle) ign_in = 1'b0;
                  else if (!stat.runner_ok) ign_in = 1'b1;
                  else state_in = ST_DEC;
               end
               pbrq_pkg::ACT_SCHEDULE: state_in = ST_SCH;
               default: ign_in = 1'b1;
            endcase
         end
         ST_DEC: begin
            if (stat.slice_expired) begin
               cmd.do_slice_load = 1'b1;
               state_in = stat.runner_queued ? ST_REM : ST_SCH;
            end else begin
               cmd.do_slice_dec = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_REM: begin
            cmd.do_remove  = 1'b1;
            priority case (act_ff)
               pbrq_pkg::ACT_TICK:    state_in = ST_INS;
               pbrq_pkg::ACT_BLOCK:   state_in = ST_SCH;
               default:               state_in = ST_FIN;
            endcase
         end
         ST_INS: begin
            cmd.do_insert     = 1'b1;
            cmd.do_slice_load = (act_ff == pbrq_pkg::ACT_CREATE);
            state_in = (act_ff == pbrq_pkg::ACT_TICK) ? ST_SCH : ST_FIN;
         end
         ST_SCH: begin
            cmd.do_schedule = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

@@ design/pbrq_datapath.sv @@
// run queue storage, links and counters
module pbrq_datapath #(
   parameter int THREADS = 256,
   parameter int LEVELS  = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pbrq_pkg::cmd_type    cmd,
   output pbrq_pkg::stat_type   stat,
   input  logic [7:0]           tid,
   input  logic [2:0]           pri,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [15:0]          csr_data,
   output logic [7:0]           cur_thread,
   output logic [7:0]           prev_thread,
   output logic                 sw,
   output logic [LEVELS-1:0]    bitmap,
   output logic [8:0]           count,
   output logic [31:0]          switches,
   output logic                 ignored
);
   localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int LW = $clog2(LEVELS);

   logic [15:0]       slice_cfg_ff;
   logic [7:0]        idle_cfg_ff;
   logic [THREADS-1:0] queued_ff;
   logic [LW-1:0]     lvl_mem [THREADS];
   logic [TW-1:0]     nxt_mem [THREADS];
   logic [TW-1:0]     prv_mem [THREADS];
   logic [15:0]       slc_mem [THREADS];
   logic [TW-1:0]     head_ff [LEVELS];
   logic [TW-1:0]     tail_ff [LEVELS];
   logic [LEVELS-1:0] nonempty_ff;
   logic [7:0]        run_ff;
   logic [8:0]        total_ff;
   logic [31:0]       sw_total_ff;
   logic [7:0]        tid_ff;
   logic [2:0]        pri_ff;
   logic [7:0]        before_ff;
   logic              sw_ff;
   logic [LW-1:0]     lv_rd_ff;
   logic [TW-1:0]     nx_rd_ff, pv_rd_ff;
   logic [15:0]       slc_rd_ff;

   logic [TW-1:0]     t_sel;
   logic [LW-1:0]     lv_ins, lv_t;
   logic [TW-1:0]     nx_t, pv_t;
   logic [TW-1:0]     ins_link;
   logic [15:0]       slc_t;
   logic              at_head, at_tail;
   logic [7:0]        pick;

   assign t_sel  = cmd.use_runner ? run_ff[TW-1:0] : tid_ff[TW-1:0];
   assign lv_t   = lv_rd_ff;
   assign nx_t   = nx_rd_ff;
   assign pv_t   = pv_rd_ff;
   assign slc_t  = slc_rd_ff;
   assign lv_ins = cmd.use_runner ? lv_t : pri_ff[LW-1:0];
   assign ins_link = nonempty_ff[lv_ins] ? tail_ff[lv_ins] : t_sel;
   assign at_head = head_ff[lv_t] == t_sel;
   assign at_tail = tail_ff[lv_t] == t_sel;

   always_comb begin
      pick = idle_cfg_ff;
      for (int l = 0; l < LEVELS; l++)
         if (nonempty_ff[l]) pick = 8'(head_ff[l]);
   end

   assign stat.queued        = queued_ff[tid_ff[TW-1:0]];
   assign stat.tid_ok        = 32'(tid_ff) < THREADS;
   assign stat.pri_ok        = 32'(pri_ff) < LEVELS;
   assign stat.runner_is_idle = run_ff == idle_cfg_ff;
   assign stat.runner_ok     = 32'(run_ff) < THREADS;
   assign stat.runner_queued = queued_ff[run_ff[TW-1:0]];
   assign stat.slice_expired = slc_t <= 16'd1;

   always_ff @(posedge clock) begin
      lv_rd_ff  <= lvl_mem[t_sel];
      nx_rd_ff  <= nxt_mem[t_sel];
      pv_rd_ff  <= prv_mem[t_sel];
      slc_rd_ff <= slc_mem[t_sel];
      if (cmd.capture) begin
         tid_ff    <= tid;
         pri_ff    <= pri;
         before_ff <= run_ff;
      end
      if (cmd.do_slice_load) slc_mem[t_sel] <= slice_cfg_ff;
      else if (cmd.do_slice_dec) slc_mem[t_sel] <= slc_t - 16'd1;
      // own next link is set when a successor joins, or to itself when the level was empty
      if (cmd.do_insert) begin
         lvl_mem[t_sel] <= lv_ins;
         nxt_mem[ins_link] <= t_sel;
         prv_mem[t_sel] <= ins_link;
         tail_ff[lv_ins] <= t_sel;
         if (!nonempty_ff[lv_ins]) head_ff[lv_ins] <= t_sel;
      end
      if (cmd.do_remove) begin
         priority if (at_head && at_tail) begin
         end else if (at_head) begin
            head_ff[lv_t] <= nx_t;
         end else if (at_tail) begin
            tail_ff[lv_t] <= pv_t;
            nxt_mem[pv_t] <= pv_t;
         end else begin
            nxt_mem[pv_t] <= nx_t;
            prv_mem[nx_t] <= pv_t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_cfg_ff <= 16'd10;
         idle_cfg_ff  <= 8'd0;
         queued_ff    <= '0;
         nonempty_ff  <= '0;
         run_ff       <= 8'd0;
         total_ff     <= 9'd0;
         sw_total_ff  <= 32'd0;
         sw_ff        <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == pbrq_pkg::CSR_SLICE) slice_cfg_ff <= csr_data;
            else idle_cfg_ff <= csr_data[7:0];
         end
         if (cmd.capture) sw_ff <= 1'b0;
         if (cmd.do_insert) begin
            nonempty_ff[lv_ins] <= 1'b1;
            queued_ff[t_sel] <= 1'b1;
            total_ff <= total_ff + 9'd1;
         end
         if (cmd.do_remove) begin
            if (at_head && at_tail) nonempty_ff[lv_t] <= 1'b0;
            queued_ff[t_sel] <= 1'b0;
            total_ff <= total_ff - 9'd1;
         end
         if (cmd.do_schedule && pick != run_ff) begin
            run_ff      <= pick;
            sw_total_ff <= sw_total_ff + 32'd1;
            sw_ff       <= 1'b1;
         end
      end
   end

   assign cur_thread  = run_ff;
   assign prev_thread = before_ff;
   assign sw          = sw_ff;
   assign bitmap      = nonempty_ff;
   assign count       = total_ff;
   assign switches    = sw_total_ff;
   assign ignored     = cmd.ignored;
endmodule

@@ design/pbrq_checker.sv @@
// port level checker for the run queue scheduler
`include "priority_bitmap_run_queue_scheduler_top_macros.svh"
module pbrq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_data
);
   `PBRQ_ASSERT_SYNC(a_reset_quiet, clock, reset |=> !rsp_valid)
   `PBRQ_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data))
   `PBRQ_ASSERT_IMPL(a_no_accept_busy, clock, reset, req_valid && req_ready |=> !req_ready)
   `PBRQ_ASSERT_IMPL(a_switch_counts, clock, reset, rsp_valid && rsp_ready && rsp_data[47] |-> rsp_data[0] == 1'b0)
endmodule

bind priority_bitmap_run_queue_scheduler_top pbrq_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
